// ===== src/lpkv_pkg.sv =====
// Shared types, constants and the home-slot hash for the linear-probe cache.
// Used by the cache core and by the entry RAM instance sizing.
package lpkv_pkg;

  // Table geometry
  localparam int SLOTS_LOG2 = 10;
  localparam int SLOT_COUNT = 1 << SLOTS_LOG2;

  // Fibonacci hash multiplier and the number of key bits dropped first
  localparam logic [63:0] HASH_MULT = 64'd11400714819323198485;
  localparam int KEY_DROP = 4;

  // Operation codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2,
    STAT_ZERO = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_PROBE
  } state_t;

  // One table entry as held in the RAM
  typedef struct packed {
    logic        used;
    logic [63:0] key;
    logic [31:0] value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Home slot: low bits of (key >> 4) * HASH_MULT. Only the low
  // SLOTS_LOG2 bits of each operand reach the low bits of the product.
  function automatic logic [SLOTS_LOG2-1:0] home_slot(input logic [63:0] k);
    logic [2*SLOTS_LOG2-1:0] prod;
    prod = k[KEY_DROP +: SLOTS_LOG2] * HASH_MULT[SLOTS_LOG2-1:0];
    return prod[SLOTS_LOG2-1:0];
  endfunction

endpackage

// ===== src/lpkv_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lpkv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/linear_probe_key_value_cache_core.sv =====
// Linear-probe key/value cache core: hash, probe sequencer and entry RAM.
// Depends on lpkv_pkg and lpkv_ram.
// Sequence: accept, ISSUE reads the home slot, PROBE checks P slots, P = slots
// probed (1 to 2^SLOTS_LOG2), then done; a zero key is answered without a probe.
// One word at a time, next accept once busy is low again; reads run one slot ahead.
// Reset: a clearing pass writes every entry empty while busy is high.
// The receiver cannot stall; done marks each result for one cycle.
module linear_probe_key_value_cache_core
  import lpkv_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic [63:0]        key,
  input  logic signed [31:0] value,
  output logic               done,
  output logic [1:0]         status,
  output logic signed [31:0] found_value
);

  state_t state, state_next;

  // Latched input word
  logic        op_r;
  logic [63:0] key_r;
  logic [31:0] value_r;

  // Probe position and count, clearing index
  logic [SLOTS_LOG2-1:0] probe_slot;
  logic [SLOTS_LOG2-1:0] probe_cnt;
  logic [SLOTS_LOG2-1:0] clr_idx;

  // Result register
  status_t     status_r;
  logic [31:0] found_r;

  // RAM signals
  logic                  ram_we;
  logic [SLOTS_LOG2-1:0] ram_waddr;
  logic [SLOTS_LOG2-1:0] ram_raddr;
  entry_t                ram_wentry;
  logic [ENTRY_W-1:0]    ram_rdata;
  entry_t                rd_entry;

  // Decode of the current probe
  logic    accept;
  logic    zero_key;
  logic    hit_empty;
  logic    hit_key;
  logic    last_probe;
  logic    finish;
  status_t res_status;
  logic [31:0] res_value;

  assign accept   = start && !busy;
  assign zero_key = (key == 64'd0);
  assign rd_entry = entry_t'(ram_rdata);

  assign hit_empty  = !rd_entry.used;
  assign hit_key    = rd_entry.used && (rd_entry.key == key_r);
  assign last_probe = (probe_cnt == {SLOTS_LOG2{1'b1}});
  assign finish     = hit_empty || hit_key || last_probe;

  lpkv_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOT_COUNT)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wentry),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == {SLOTS_LOG2{1'b1}}) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && !zero_key) state_next = ST_ISSUE;
      end
      ST_ISSUE: state_next = ST_PROBE;
      ST_PROBE: begin
        if (finish) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // RAM control and result decode
  always_comb begin
    busy       = (state != ST_IDLE);
    ram_we     = 1'b0;
    ram_waddr  = probe_slot;
    ram_raddr  = probe_slot;
    ram_wentry = '{used: 1'b1, key: key_r, value: value_r};
    res_status = STAT_MISS;
    res_value  = 32'd0;

    // Probe outcome
    if (hit_empty) begin
      res_status = (op_r == OP_INSERT) ? STAT_OK : STAT_MISS;
    end else if (hit_key) begin
      res_status = STAT_OK;
      if (op_r == OP_LOOKUP) res_value = rd_entry.value;
    end else begin
      res_status = (op_r == OP_INSERT) ? STAT_FULL : STAT_MISS;
    end

    unique case (state)
      ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_idx;
        ram_wentry = '{used: 1'b0, key: 64'd0, value: 32'd0};
      end
      ST_IDLE:  ram_raddr = probe_slot;
      ST_ISSUE: ram_raddr = probe_slot;
      ST_PROBE: begin
        // read one slot ahead while the current slot is checked
        ram_raddr = probe_slot + 1'b1;
        ram_we    = (op_r == OP_INSERT) && (hit_empty || hit_key);
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      probe_cnt <= '0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == ST_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (accept) begin
        probe_cnt <= '0;
        done      <= zero_key;
      end else if (state == ST_PROBE) begin
        probe_cnt <= probe_cnt + 1'b1;
        done      <= finish;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= op;
      key_r      <= key;
      value_r    <= value;
      probe_slot <= home_slot(key);
      status_r   <= STAT_ZERO;
      found_r    <= 32'd0;
    end else if (state == ST_PROBE) begin
      probe_slot <= probe_slot + 1'b1;
      status_r   <= res_status;
      found_r    <= res_value;
    end
  end

  assign status      = status_r;
  assign found_value = found_r;

`ifndef ASSERT_OFF
  // A result is only shown once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  // RAM writes come only from the clearing pass or the final probe
  a_we_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLEAR || state == ST_PROBE))
    else $error("unexpected RAM write");

  // A zero key is rejected in the next cycle
  a_zero_key: assert property (@(posedge clk) disable iff (rst)
    (accept && zero_key) |=> (done && status == STAT_ZERO))
    else $error("zero key not rejected");

  // A nonzero value is returned only with a successful lookup
  a_value_ok: assert property (@(posedge clk) disable iff (rst)
    (done && found_value != 32'sd0) |-> (status == STAT_OK))
    else $error("value on failed access");

  // The home-slot read is always followed by a probe
  a_issue_probe: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ISSUE) |=> (state == ST_PROBE))
    else $error("issue not followed by probe");
`endif

endmodule

// ===== tb/linear_probe_key_value_cache_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench for linear_probe_key_value_cache_core: directed table, then random
// lookups and inserts that fill the table up and then keep working on it when full.
// Depends on lpkv_pkg and the core RTL; words are checked to typed rows or a shadow table.
module linear_probe_key_value_cache_core_tb;
  import lpkv_pkg::*;

  localparam int IDLE_LIMIT = 8 * SLOT_COUNT + 500;
  localparam int MIXED_WORDS = 450;
  localparam int FULL_WORDS = 50;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] found;
  } cache_reply_t;

  typedef struct packed {
    logic               op;
    logic [63:0]        key;
    logic signed [31:0] value;
    bit                 typed;
    status_t            status;
    logic signed [31:0] found;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               op = OP_LOOKUP;
  logic [63:0]        key = '0;
  logic signed [31:0] value = '0;
  logic               done;
  logic [1:0]         status;
  logic signed [31:0] found_value;

  // Shadow copy of the table
  bit                 shadow_used [SLOT_COUNT];
  logic [63:0]        shadow_key [SLOT_COUNT];
  logic signed [31:0] shadow_val [SLOT_COUNT];
  int                 shadow_entries = 0;
  logic [63:0]        stored_keys[$];

  cache_reply_t pending_replies[$];
  stim_row_t    directed_rows[$];

  int  mismatches = 0;
  int  idle_cycles = 0;
  int  words_sent = 0;
  int  inserts_sent = 0;
  int  deepest_probe = 0;
  int  status_seen [4];
  bit  burst_mode = 1'b0;

  linear_probe_key_value_cache_core dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .key         (key),
    .value       (value),
    .done        (done),
    .status      (status),
    .found_value (found_value)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Expected answer of one access; updates the shadow table like the block does
  function automatic cache_reply_t predict_access(input logic op_in, input logic [63:0] k,
                                                  input logic signed [31:0] v);
    cache_reply_t          r;
    logic [63:0]           prod;
    logic [SLOTS_LOG2-1:0] idx;
    int                    n;
    r.found = '0;
    if (k == '0) begin
      r.status = STAT_ZERO;
      return r;
    end
    r.status = (op_in == OP_INSERT) ? STAT_FULL : STAT_MISS;
    prod = (k >> KEY_DROP) * HASH_MULT;
    idx = prod[SLOTS_LOG2-1:0];
    for (n = 0; n < SLOT_COUNT; n++) begin
      if (!shadow_used[idx]) begin
        if (op_in == OP_INSERT) begin
          shadow_used[idx] = 1'b1;
          shadow_key[idx] = k;
          shadow_val[idx] = v;
          shadow_entries++;
          stored_keys.insert(stored_keys.size(), k);
          r.status = STAT_OK;
        end else begin
          r.status = STAT_MISS;
        end
        break;
      end else if (shadow_key[idx] == k) begin
        if (op_in == OP_INSERT) shadow_val[idx] = v;
        else r.found = shadow_val[idx];
        r.status = STAT_OK;
        break;
      end
      idx = idx + 1'b1;
    end
    if (n + 1 > deepest_probe) deepest_probe = (n < SLOT_COUNT) ? n + 1 : SLOT_COUNT;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(60, 8);
  endfunction

  // Keys: zero, reuse of stored keys, same-home neighbors, single bits, fully random
  function automatic logic [63:0] pick_key();
    int          r;
    logic [63:0] k;
    r = $urandom_range(99);
    if (r < 3) return '0;
    if (stored_keys.size() != 0) begin
      k = stored_keys[$urandom_range(stored_keys.size() - 1)];
      if (r < 45) return k;
      if (r < 65) return {k[63:4], 4'($urandom)};
    end
    if (r < 70) return 64'd1 << $urandom_range(63);
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(19))
      0: return '0;
      1: return 32'sh8000_0000;
      2: return 32'sh7fff_ffff;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void row(input logic op_in, input logic [63:0] k,
                              input logic signed [31:0] v, input bit typed,
                              input status_t st, input logic signed [31:0] fv);
    stim_row_t s;
    s.op = op_in;
    s.key = k;
    s.value = v;
    s.typed = typed;
    s.status = st;
    s.found = fv;
    directed_rows.insert(directed_rows.size(), s);
  endfunction

  // Drive one word; returns once it is accepted and its answer is queued
  task automatic send_request(input logic op_in, input logic [63:0] k,
                              input logic signed [31:0] v, input bit typed,
                              input cache_reply_t typed_reply);
    int           gap;
    cache_reply_t model_reply;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    op <= op_in;
    key <= k;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    model_reply = predict_access(op_in, k, v);
    pending_replies.insert(pending_replies.size(), typed ? typed_reply : model_reply);
    words_sent++;
    if (op_in == OP_INSERT) inserts_sent++;
  endtask

  task automatic send_random(input logic op_in, input logic [63:0] k);
    send_request(op_in, k, pick_value(), 1'b0, '0);
  endtask

  // Result checker
  always @(posedge clk) begin
    cache_reply_t exp_reply;
    if (!rst && done) begin
      status_seen[status]++;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result with nothing pending: status=%0d found=%0d",
                   $time, status, found_value);
      end else begin
        exp_reply = pending_replies.pop_front();
        if (status !== exp_reply.status || found_value !== exp_reply.found) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch: status exp %0d got %0d, found_value exp %0d got %0d",
                     $time, exp_reply.status, status, exp_reply.found, found_value);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    cache_reply_t t;
    int           i;
    foreach (status_seen[j]) status_seen[j] = 0;

    // Directed rows on an empty table
    row(OP_LOOKUP, 64'h1234_5678_9abc_def0, 32'sd0, 1, STAT_MISS, 0);
    row(OP_LOOKUP, 64'h0, 32'sd0, 1, STAT_ZERO, 0);
    row(OP_INSERT, 64'h0, 32'sd5, 1, STAT_ZERO, 0);
    row(OP_INSERT, 64'hffff_ffff_ffff_ffff, 32'sh7fff_ffff, 1, STAT_OK, 0);
    row(OP_LOOKUP, 64'hffff_ffff_ffff_ffff, 32'sd0, 1, STAT_OK, 32'sh7fff_ffff);
    row(OP_INSERT, 64'h1, 32'sh8000_0000, 1, STAT_OK, 0);
    row(OP_LOOKUP, 64'h1, 32'sd0, 1, STAT_OK, 32'sh8000_0000);
    // keys sharing key>>4 share a home slot: build a probe chain
    row(OP_INSERT, 64'h10, 32'sd0, 1, STAT_OK, 0);
    row(OP_INSERT, 64'h11, 32'sd7, 0, STAT_OK, 0);
    row(OP_INSERT, 64'h1f, -32'sd1, 0, STAT_OK, 0);
    row(OP_LOOKUP, 64'h11, 32'sd0, 0, STAT_OK, 0);
    row(OP_LOOKUP, 64'h1f, 32'sd0, 0, STAT_OK, 0);
    row(OP_LOOKUP, 64'h12, 32'sd0, 0, STAT_OK, 0);
    // update keeps the entry, new value visible
    row(OP_INSERT, 64'h11, 32'sh55, 1, STAT_OK, 0);
    row(OP_LOOKUP, 64'h11, 32'sd0, 1, STAT_OK, 32'sh55);
    row(OP_LOOKUP, 64'h10, 32'sd0, 1, STAT_OK, 0);
    row(OP_INSERT, 64'h8000_0000_0000_0000, 32'sd1, 1, STAT_OK, 0);
    row(OP_LOOKUP, 64'h8000_0000_0000_0000, 32'shdead_beef, 1, STAT_OK, 32'sd1);
    row(OP_LOOKUP, 64'h0f, 32'sd0, 0, STAT_OK, 0);
    row(OP_INSERT, 64'h0f, 32'sh1234_5678, 1, STAT_OK, 0);
    row(OP_LOOKUP, 64'h0f, 32'sd0, 1, STAT_OK, 32'sh1234_5678);
    row(OP_INSERT, 64'haaaa_aaaa_5555_5555, 32'sh5555_5555, 1, STAT_OK, 0);
    row(OP_LOOKUP, 64'haaaa_aaaa_5555_5555, -32'sd1, 1, STAT_OK, 32'sh5555_5555);
    row(OP_INSERT, 64'haaaa_aaaa_5555_5555, 32'shaaaa_aaaa, 0, STAT_OK, 0);
    row(OP_LOOKUP, 64'haaaa_aaaa_5555_5555, 32'sd0, 0, STAT_OK, 0);

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[j]) begin
      t.status = directed_rows[j].status;
      t.found = directed_rows[j].found;
      send_request(directed_rows[j].op, directed_rows[j].key, directed_rows[j].value,
                   directed_rows[j].typed, t);
    end

    // Mixed traffic at low and medium load
    for (i = 0; i < MIXED_WORDS; i++) begin
      if (i % 50 == 0) burst_mode = ($urandom_range(99) < 25);
      send_random(($urandom_range(99) < 55) ? OP_INSERT : OP_LOOKUP, pick_key());
    end

    // Fill up to the last slot; clusters get long near the end
    i = 0;
    while (shadow_entries < SLOT_COUNT) begin
      if (i % 50 == 0) burst_mode = ($urandom_range(99) < 25);
      if ($urandom_range(99) < 85) send_random(OP_INSERT, {$urandom, $urandom});
      else send_random(($urandom_range(1) != 0) ? OP_INSERT : OP_LOOKUP, pick_key());
      i++;
    end

    // Full table: misses scan every slot, new keys are refused, updates still land
    burst_mode = 1'b0;
    for (i = 0; i < FULL_WORDS; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: send_random(OP_LOOKUP, {$urandom, $urandom});
        4, 5, 6:    send_random(OP_INSERT, {$urandom, $urandom});
        default:    send_random(($urandom_range(1) != 0) ? OP_INSERT : OP_LOOKUP, pick_key());
      endcase
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SLOT_COUNT + 8) @(posedge clk);

    $display("Ran %0d words (%0d inserts, %0d lookups); answers ok=%0d miss=%0d full=%0d zero=%0d",
             words_sent, inserts_sent, words_sent - inserts_sent,
             status_seen[STAT_OK], status_seen[STAT_MISS], status_seen[STAT_FULL],
             status_seen[STAT_ZERO]);
    $display("Table filled %0d of %0d slots, longest probe %0d slots, %0d mismatches",
             shadow_entries, SLOT_COUNT, deepest_probe, mismatches);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/lpkv_pkg.sv
src/lpkv_ram.sv
src/linear_probe_key_value_cache_core.sv
tb/linear_probe_key_value_cache_core_tb.sv
